// ===== sv/fdd_pkg.sv =====
`timescale 1ns / 1ps
// fdd_pkg: shared types and constants of the finite difference derivative block
// no dependencies

package fdd_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    // growth of the stencil numerator over the sample width
    localparam int NUM_GROWTH       = 5;
    localparam int INV_WIDTH        = 16;
    localparam int SLOPE_WIDTH      = 32;
    localparam int CFG_INDEX_WIDTH  = 1;
    localparam int CFG_DATA_WIDTH   = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODE     = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INV_STEP = 1'b1;

    localparam logic [INV_WIDTH-1:0] INV_STEP_RESET = 16'd256;

    // right shifts for the denominators 1, 2 and 12 (12 = 3 after the shift)
    localparam int SHIFT_ONE    = 8;
    localparam int SHIFT_TWO    = 9;
    localparam int SHIFT_TWELVE = 10;

    // unsigned divide by 3 as multiply by ceil(2^34 / 3), valid below 2^33
    localparam int               DIV3_IN_WIDTH = 33;
    localparam int               DIV3_SHIFT    = 34;
    localparam logic [32:0]      DIV3_MAGIC    = 33'h1_5555_5556;
    // 3 * 2^31: first magnitude whose quotient leaves the 32-bit range
    localparam logic [32:0]      DIV3_LIMIT    = 33'h1_8000_0000;

    localparam logic [SLOPE_WIDTH-1:0] SLOPE_MAX = 32'h7fff_ffff;
    localparam logic [SLOPE_WIDTH-1:0] SLOPE_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        MODE_FWD,
        MODE_BWD,
        MODE_CENTRAL,
        MODE_FIVE
    } t_mode;

    typedef enum logic [1:0] {
        DEN_ONE,
        DEN_TWO,
        DEN_TWELVE
    } t_den;

    typedef struct packed {
        logic fin;
        logic too_short;
    } t_flags;

    typedef struct packed {
        logic div3;
        logic neg;
        logic clip;
    } t_norm;

endpackage

// ===== sv/finite_difference_derivative.sv =====
`timescale 1ns / 1ps
// finite_difference_derivative: top level, configuration registers and stage chain
// depends on fdd_pkg, fdd_front, fdd_scale, fdd_out
//
//  channel   dir  handshake                        payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: sample; tlast: last
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: slope; tlast: final_res;
//                                                  tuser: too_short, clipped
//  cfg       in   i_cfg_valid/o_cfg_ready          index 0 mode, 1 inverse_step
//
//  one word per cycle while no results are owed; a word releases at most one result,
//  except the last word of a sequence, which releases up to three and holds the input
//  until the last is emitted (the front sequencer emits one result per cycle unless
//  stalled); the first result of a word passes the job, numerator, product, normalize
//  and output registers to m_axis; flush results follow one per cycle unless stalled
//  every stage holds under output stall; bubbles still let input words in
//  synchronous active-low reset clears history, count, valids and config to defaults

module finite_difference_derivative import fdd_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [SAMPLE_WIDTH-1:0] sample, upper bits zero fill
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     i_s_axis_tdata,
    input  logic                                  i_s_axis_tlast,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [31:0] slope
    output logic [SLOPE_WIDTH-1:0]                o_m_axis_tdata,
    // [0] too_short, [1] clipped
    output logic [1:0]                            o_m_axis_tuser,
    output logic                                  o_m_axis_tlast,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]            i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]             i_cfg_data
);

    localparam int NW = SAMPLE_WIDTH + NUM_GROWTH;

    t_mode                r_mode;
    logic [INV_WIDTH-1:0] r_inv_step;

    logic                 f_valid, f_ready;
    logic signed [NW-1:0] f_num;
    t_den                 f_den;
    t_flags               f_flags;

    logic                     s_valid, s_ready;
    logic [SLOPE_WIDTH-1:0]   s_val;
    logic [DIV3_IN_WIDTH-1:0] s_y;
    t_norm                    s_norm;
    t_flags                   s_flags;

    logic too_short, clipped;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_FWD;
            r_inv_step <= INV_STEP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:     r_mode     <= t_mode'(i_cfg_data[1:0]);
                CFG_INV_STEP: r_inv_step <= i_cfg_data[INV_WIDTH-1:0];
                default:      r_mode     <= r_mode;
            endcase
        end
    end

    fdd_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode   (r_mode),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_sample ($signed(i_s_axis_tdata[SAMPLE_WIDTH-1:0])),
        .i_last   (i_s_axis_tlast),
        .o_valid  (f_valid),
        .i_ready  (f_ready),
        .o_num    (f_num),
        .o_den    (f_den),
        .o_flags  (f_flags)
    );

    fdd_scale #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_inv_step (r_inv_step),
        .i_valid    (f_valid),
        .o_ready    (f_ready),
        .i_num      (f_num),
        .i_den      (f_den),
        .i_flags    (f_flags),
        .o_valid    (s_valid),
        .i_ready    (s_ready),
        .o_val      (s_val),
        .o_y        (s_y),
        .o_norm     (s_norm),
        .o_flags    (s_flags)
    );

    fdd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_valid),
        .o_ready     (s_ready),
        .i_val       (s_val),
        .i_y         (s_y),
        .i_norm      (s_norm),
        .i_flags     (s_flags),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_slope     (o_m_axis_tdata),
        .o_fin       (o_m_axis_tlast),
        .o_too_short (too_short),
        .o_clipped   (clipped)
    );

    assign o_m_axis_tuser = {clipped, too_short};

endmodule

// ===== sv/fdd_front.sv =====
`timescale 1ns / 1ps
// fdd_front: sample history, per-word result sequencing and stencil numerator
// depends on fdd_pkg

module fdd_front import fdd_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  t_mode                                   i_mode,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_sample,
    input  logic                                    i_last,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [SAMPLE_WIDTH+NUM_GROWTH-1:0] o_num,
    output t_den                                    o_den,
    output t_flags                                  o_flags
);

    localparam int NW = SAMPLE_WIDTH + NUM_GROWTH;

    // history: index 0 newest
    logic signed [SAMPLE_WIDTH-1:0] r_hist [4];
    logic [2:0]                     r_seen;

    // job: window of five samples and the results still owed for it
    logic                           r_job_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_g [5];
    logic [2:0]                     r_job_k;
    logic                           r_job_last;
    logic                           r_job_short;
    logic [1:0]                     r_job_rem;

    logic                           r_v1;
    logic signed [NW-1:0]           r_num;
    t_den                           r_den;
    t_flags                         r_flags;

    logic s1_ready, emit, job_done, accept;
    logic job_has, job_short;
    logic [1:0] job_rem;

    logic [2:0] a;
    logic       a_is0, a_is1, b_is0, b_is1, b_ge1;
    logic [1:0] jsel;
    logic signed [SAMPLE_WIDTH-1:0] wm2, wm1, w0, wp1, wp2;
    logic signed [NW-1:0] d_fwd, d_bwd, d_cen, d_five;
    logic signed [NW-1:0] n_num;
    t_den                 n_den;
    t_flags               n_flags;

    assign s1_ready = !r_v1 || i_ready;
    assign emit     = r_job_valid && s1_ready;
    assign job_done = emit && (r_job_rem == 2'd0);
    assign o_ready  = !r_job_valid || job_done;
    assign accept   = i_valid && o_ready;

    // what the incoming word owes
    always_comb begin
        job_short = (r_seen == 3'd0) || ((i_mode == MODE_FIVE) && (r_seen == 3'd1));
        job_has   = i_last || (r_seen >= 3'd2);
        if (!i_last) begin
            job_rem = 2'd0;
        end else if (job_short || (r_seen < 3'd2)) begin
            job_rem = r_seen[1:0];
        end else begin
            job_rem = 2'd2;
        end
    end

    // position of the result being emitted
    always_comb begin
        if (r_job_last) begin
            a     = 3'(r_job_k - {1'b0, r_job_rem});
            b_is0 = (r_job_rem == 2'd0);
            b_is1 = (r_job_rem == 2'd1);
            b_ge1 = (r_job_rem != 2'd0);
            jsel  = r_job_rem;
        end else begin
            a     = 3'(r_job_k - 3'd2);
            b_is0 = 1'b0;
            b_is1 = 1'b0;
            b_ge1 = 1'b1;
            jsel  = 2'd2;
        end
        a_is0 = (a == 3'd0);
        a_is1 = (a == 3'd1);
    end

    always_comb begin
        case (jsel)
            2'd1: begin
                wm2 = r_g[1]; wm1 = r_g[2]; w0 = r_g[3]; wp1 = r_g[4]; wp2 = '0;
            end
            2'd0: begin
                wm2 = r_g[2]; wm1 = r_g[3]; w0 = r_g[4]; wp1 = '0; wp2 = '0;
            end
            default: begin
                wm2 = r_g[0]; wm1 = r_g[1]; w0 = r_g[2]; wp1 = r_g[3]; wp2 = r_g[4];
            end
        endcase
    end

    assign d_fwd  = NW'(wp1) - NW'(w0);
    assign d_bwd  = NW'(w0) - NW'(wm1);
    assign d_cen  = NW'(wp1) - NW'(wm1);
    assign d_five = (NW'(wm2) - NW'(wp2)) + (d_cen <<< 3);

    always_comb begin
        n_den = DEN_ONE;
        unique case (i_mode)
            MODE_FWD: n_num = b_ge1 ? d_fwd : d_bwd;
            MODE_BWD: n_num = a_is0 ? d_fwd : d_bwd;
            MODE_CENTRAL: begin
                if (a_is0) begin
                    n_num = d_fwd;
                end else if (b_is0) begin
                    n_num = d_bwd;
                end else begin
                    n_num = d_cen;
                    n_den = DEN_TWO;
                end
            end
            MODE_FIVE: begin
                if (a_is0) begin
                    n_num = d_fwd;
                end else if (b_is0) begin
                    n_num = d_bwd;
                end else if (a_is1 || b_is1) begin
                    n_num = d_cen;
                    n_den = DEN_TWO;
                end else begin
                    n_num = d_five;
                    n_den = DEN_TWELVE;
                end
            end
            default: n_num = d_fwd;
        endcase
        n_flags.fin       = r_job_last && (r_job_rem == 2'd0);
        n_flags.too_short = r_job_short;
        if (r_job_short) begin
            n_num = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist[0]   <= '0;
            r_hist[1]   <= '0;
            r_hist[2]   <= '0;
            r_hist[3]   <= '0;
            r_seen      <= '0;
            r_job_valid <= 1'b0;
            r_v1        <= 1'b0;
        end else begin
            if (accept) begin
                if (i_last) begin
                    r_hist[0] <= '0;
                    r_hist[1] <= '0;
                    r_hist[2] <= '0;
                    r_hist[3] <= '0;
                    r_seen    <= '0;
                end else begin
                    r_hist[0] <= i_sample;
                    r_hist[1] <= r_hist[0];
                    r_hist[2] <= r_hist[1];
                    r_hist[3] <= r_hist[2];
                    r_seen    <= (r_seen == 3'd7) ? r_seen : 3'(r_seen + 3'd1);
                end
                r_job_valid <= job_has;
            end else if (job_done) begin
                r_job_valid <= 1'b0;
            end
            if (s1_ready) begin
                r_v1 <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_g[0]      <= r_hist[3];
            r_g[1]      <= r_hist[2];
            r_g[2]      <= r_hist[1];
            r_g[3]      <= r_hist[0];
            r_g[4]      <= i_sample;
            r_job_k     <= r_seen;
            r_job_last  <= i_last;
            r_job_short <= i_last && job_short;
            r_job_rem   <= job_rem;
        end else if (emit && !job_done) begin
            r_job_rem <= r_job_rem - 2'd1;
        end
        if (emit) begin
            r_num   <= n_num;
            r_den   <= n_den;
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_v1;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_flags = r_flags;

endmodule

// ===== sv/fdd_scale.sv =====
`timescale 1ns / 1ps
// fdd_scale: multiply by inverse step, floor shift and saturation prep
// depends on fdd_pkg

module fdd_scale import fdd_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic [INV_WIDTH-1:0]                    i_inv_step,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [SAMPLE_WIDTH+NUM_GROWTH-1:0] i_num,
    input  t_den                                    i_den,
    input  t_flags                                  i_flags,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [SLOPE_WIDTH-1:0]                  o_val,
    output logic [DIV3_IN_WIDTH-1:0]                o_y,
    output t_norm                                   o_norm,
    output t_flags                                  o_flags
);

    localparam int NW = SAMPLE_WIDTH + NUM_GROWTH;
    localparam int PW = NW + INV_WIDTH + 1;
    localparam int XW = (PW > DIV3_SHIFT) ? PW : DIV3_SHIFT;

    logic                 r_v2, r_v3;
    logic signed [PW-1:0] r_p;
    t_den                 r_den2;
    t_flags               r_flags2, r_flags3;
    logic [SLOPE_WIDTH-1:0]   r_val;
    logic [DIV3_IN_WIDTH-1:0] r_y;
    t_norm                    r_norm;

    logic s2_ready, s3_ready;
    logic signed [PW-1:0] n_p;
    logic signed [XW-1:0] x;
    logic [XW-1:0]        y;
    logic                 x_ovf, y_ovf;
    logic [SLOPE_WIDTH-1:0] n_val;
    t_norm                n_norm;

    assign s3_ready = !r_v3 || i_ready;
    assign s2_ready = !r_v2 || s3_ready;
    assign o_ready  = s2_ready;

    assign n_p = PW'(i_num) * PW'($signed({1'b0, i_inv_step}));

    always_comb begin
        case (r_den2)
            DEN_TWO:    x = XW'(r_p) >>> SHIFT_TWO;
            DEN_TWELVE: x = XW'(r_p) >>> SHIFT_TWELVE;
            default:    x = XW'(r_p) >>> SHIFT_ONE;
        endcase
    end

    // fits 32 bits when all bits from 31 up agree
    assign x_ovf = !((&x[XW-1:SLOPE_WIDTH-1]) || !(|x[XW-1:SLOPE_WIDTH-1]));
    assign n_val = x_ovf ? (x[XW-1] ? SLOPE_MIN : SLOPE_MAX) : x[SLOPE_WIDTH-1:0];

    // floor(x/3) = ~floor(~x/3) for negative x
    assign y     = x[XW-1] ? ~x : x;
    assign y_ovf = (|y[XW-1:DIV3_IN_WIDTH]) || (y[DIV3_IN_WIDTH-1:0] >= DIV3_LIMIT);

    always_comb begin
        n_norm.div3 = (r_den2 == DEN_TWELVE);
        n_norm.neg  = x[XW-1];
        n_norm.clip = n_norm.div3 ? y_ovf : x_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (s2_ready) begin
                r_v2 <= i_valid;
            end
            if (s3_ready) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && i_valid) begin
            r_p      <= n_p;
            r_den2   <= i_den;
            r_flags2 <= i_flags;
        end
        if (s3_ready && r_v2) begin
            r_val    <= n_val;
            r_y      <= y[DIV3_IN_WIDTH-1:0];
            r_norm   <= n_norm;
            r_flags3 <= r_flags2;
        end
    end

    assign o_valid = r_v3;
    assign o_val   = r_val;
    assign o_y     = r_y;
    assign o_norm  = r_norm;
    assign o_flags = r_flags3;

endmodule

// ===== sv/fdd_out.sv =====
`timescale 1ns / 1ps
// fdd_out: divide by three for the five-point stencil and result register
// depends on fdd_pkg

module fdd_out import fdd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [SLOPE_WIDTH-1:0]   i_val,
    input  logic [DIV3_IN_WIDTH-1:0] i_y,
    input  t_norm                    i_norm,
    input  t_flags                   i_flags,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [SLOPE_WIDTH-1:0]   o_slope,
    output logic                     o_fin,
    output logic                     o_too_short,
    output logic                     o_clipped
);

    localparam int PRODW = 2 * DIV3_IN_WIDTH;

    logic                   r_valid;
    logic [SLOPE_WIDTH-1:0] r_slope;
    logic                   r_fin, r_too_short, r_clipped;

    logic                   out_ready;
    logic [PRODW-1:0]       prod;
    logic [SLOPE_WIDTH-1:0] q3;
    logic [SLOPE_WIDTH-1:0] n_slope;
    logic                   n_clipped;

    assign out_ready = !r_valid || i_ready;
    assign o_ready   = out_ready;

    assign prod = PRODW'(i_y) * PRODW'(DIV3_MAGIC);
    assign q3   = prod[DIV3_SHIFT+SLOPE_WIDTH-1:DIV3_SHIFT];

    always_comb begin
        if (i_flags.too_short) begin
            n_slope   = '0;
            n_clipped = 1'b0;
        end else if (i_norm.div3) begin
            n_clipped = i_norm.clip;
            if (i_norm.clip) begin
                n_slope = i_norm.neg ? SLOPE_MIN : SLOPE_MAX;
            end else begin
                n_slope = i_norm.neg ? ~q3 : q3;
            end
        end else begin
            n_slope   = i_val;
            n_clipped = i_norm.clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && i_valid) begin
            r_slope     <= n_slope;
            r_fin       <= i_flags.fin;
            r_too_short <= i_flags.too_short;
            r_clipped   <= n_clipped;
        end
    end

    assign o_valid     = r_valid;
    assign o_slope     = r_slope;
    assign o_fin       = r_fin;
    assign o_too_short = r_too_short;
    assign o_clipped   = r_clipped;

endmodule

// ===== tb/fdd_checker.sv =====
`timescale 1ns / 1ps
// fdd_checker: watches the sample, result and register channels, predicts each slope
// and compares the results field by field; depends on fdd_pkg

module fdd_checker import fdd_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_valid,
    input  logic                    i_s_ready,
    input  logic [SAMPLE_WIDTH-1:0] i_s_data,
    input  logic                    i_s_last,
    input  logic                    i_m_valid,
    input  logic                    i_m_ready,
    input  logic [SLOPE_WIDTH-1:0]  i_m_data,
    input  logic [1:0]              i_m_user,
    input  logic                    i_m_last,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_results
);

    localparam int     USER_TOO_SHORT = 0;
    localparam int     USER_CLIPPED   = 1;
    localparam longint SLOPE_HI       = 64'sd2147483647;
    localparam longint SLOPE_LO       = -64'sd2147483648;
    localparam int     SEEN_MAX       = 7;
    // samples a sequence needs before real differences are possible
    localparam int     NEED_FIVE      = 3;
    localparam int     NEED_OTHER     = 2;

    typedef struct packed {
        logic [SLOPE_WIDTH-1:0] slope;
        logic                   fin;
        logic                   too_short;
        logic                   clipped;
    } t_deriv;

    t_deriv              pending_slopes[$];
    t_mode               mode_r;
    logic [INV_WIDTH-1:0] inv_step_r;
    longint              hist[0:3];   // hist[0] is the newest sample
    longint              win[0:4];    // oldest to newest, win[4] the incoming one
    int                  seen;
    int                  err_cnt;
    int                  res_cnt;

    function automatic longint tap(input int idx);
        if (idx < 0 || idx > 4)
            return 0;
        return win[idx];
    endfunction

    // a: positions from the start, b: positions to the end, j: window index
    function automatic t_deriv stencil_slope(input int a, input int b, input int j,
                                             input logic fin);
        longint num;
        longint den;
        longint p;
        longint d;
        longint q;
        t_deriv r;
        den = 1;
        case (mode_r)
            MODE_FWD: begin
                num = (b >= 1) ? tap(j + 1) - tap(j) : tap(j) - tap(j - 1);
            end
            MODE_BWD: begin
                num = (a >= 1) ? tap(j) - tap(j - 1) : tap(j + 1) - tap(j);
            end
            MODE_CENTRAL: begin
                if (a == 0) begin
                    num = tap(j + 1) - tap(j);
                end else if (b == 0) begin
                    num = tap(j) - tap(j - 1);
                end else begin
                    num = tap(j + 1) - tap(j - 1);
                    den = 2;
                end
            end
            default: begin
                if (a == 0) begin
                    num = tap(j + 1) - tap(j);
                end else if (b == 0) begin
                    num = tap(j) - tap(j - 1);
                end else if (a == 1 || b == 1) begin
                    num = tap(j + 1) - tap(j - 1);
                    den = 2;
                end else begin
                    num = tap(j - 2) - tap(j + 2) + 8 * (tap(j + 1) - tap(j - 1));
                    den = 12;
                end
            end
        endcase
        p = num * longint'({48'd0, inv_step_r});
        d = den * 256;
        q = p / d;
        // round toward minus infinity
        if ((p % d) != 0 && p < 0)
            q = q - 1;
        r.clipped = 1'b0;
        if (q > SLOPE_HI) begin
            q = SLOPE_HI;
            r.clipped = 1'b1;
        end
        if (q < SLOPE_LO) begin
            q = SLOPE_LO;
            r.clipped = 1'b1;
        end
        r.slope     = q[SLOPE_WIDTH-1:0];
        r.fin       = fin;
        r.too_short = 1'b0;
        return r;
    endfunction

    task automatic take_sample(input logic [SAMPLE_WIDTH-1:0] data, input logic lst);
        int     k;
        int     need;
        int     i;
        int     rmax;
        t_deriv r;
        k = seen;
        win[0] = hist[3];
        win[1] = hist[2];
        win[2] = hist[1];
        win[3] = hist[0];
        win[4] = longint'($signed(data));
        if (!lst) begin
            if (k >= 2)
                pending_slopes.push_back(stencil_slope(k - 2, 3, 2, 1'b0));
            hist[3] = hist[2];
            hist[2] = hist[1];
            hist[1] = hist[0];
            hist[0] = win[4];
            seen    = (k < SEEN_MAX) ? k + 1 : SEEN_MAX;
        end else begin
            need = (mode_r == MODE_FIVE) ? NEED_FIVE : NEED_OTHER;
            if (k + 1 < need) begin
                for (i = 0; i <= k; i++) begin
                    r.slope     = '0;
                    r.fin       = (i == k);
                    r.too_short = 1'b1;
                    r.clipped   = 1'b0;
                    pending_slopes.push_back(r);
                end
            end else begin
                // flush the positions still waiting, the last one marked
                rmax = (k < 2) ? k : 2;
                for (i = rmax; i >= 0; i--)
                    pending_slopes.push_back(stencil_slope(k - i, i, 4 - i, i == 0));
            end
            for (i = 0; i < 4; i++)
                hist[i] = 0;
            seen = 0;
        end
    endtask

    always @(posedge i_clk) begin
        t_deriv want;
        if (!i_rst_n) begin
            mode_r     = MODE_FWD;
            inv_step_r = INV_STEP_RESET;
            for (int i = 0; i < 4; i++)
                hist[i] = 0;
            seen    = 0;
            err_cnt = 0;
            res_cnt = 0;
            pending_slopes.delete();
        end else begin
            // results first: a word taken at this edge cannot release one yet
            if (i_m_valid && i_m_ready) begin
                res_cnt++;
                if (pending_slopes.size() == 0) begin
                    $error("unexpected result word: slope %0d", $signed(i_m_data));
                    err_cnt++;
                end else begin
                    want = pending_slopes.pop_front();
                    if (i_m_data !== want.slope) begin
                        $error("slope: expected %0d, got %0d",
                               $signed(want.slope), $signed(i_m_data));
                        err_cnt++;
                    end
                    if (i_m_last !== want.fin) begin
                        $error("final_res: expected %0b, got %0b", want.fin, i_m_last);
                        err_cnt++;
                    end
                    if (i_m_user[USER_TOO_SHORT] !== want.too_short) begin
                        $error("too_short: expected %0b, got %0b",
                               want.too_short, i_m_user[USER_TOO_SHORT]);
                        err_cnt++;
                    end
                    if (i_m_user[USER_CLIPPED] !== want.clipped) begin
                        $error("clipped: expected %0b, got %0b",
                               want.clipped, i_m_user[USER_CLIPPED]);
                        err_cnt++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MODE:     mode_r     = t_mode'(i_cfg_data[1:0]);
                    CFG_INV_STEP: inv_step_r = i_cfg_data;
                    default:      ;
                endcase
            end
            if (i_s_valid && i_s_ready)
                take_sample(i_s_data, i_s_last);
        end
        o_errors  <= err_cnt;
        o_results <= res_cnt;
        o_pending <= pending_slopes.size();
    end

endmodule

// ===== tb/tb_finite_difference_derivative.sv =====
`timescale 1ns / 1ps
// tb_finite_difference_derivative: drives sample sequences and register writes into the
// derivative block under random flow control; depends on fdd_pkg, fdd_checker and the block

module tb_finite_difference_derivative;
    import fdd_pkg::*;

    localparam int SW            = SAMPLE_WIDTH_DEF;
    localparam int DW            = ((SW + 7) / 8) * 8;
    localparam int RANDOM_WORDS  = 320;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES   = 20;
    localparam int CYCLE_LIMIT   = 400000;

    localparam int SHAPE_NOISE   = 0;
    localparam int SHAPE_EXTREME = 1;
    localparam int SHAPE_RAMP    = 2;
    localparam int SHAPE_SMALL   = 3;

    localparam logic [SW-1:0] S_MAX = {1'b0, {(SW - 1){1'b1}}};
    localparam logic [SW-1:0] S_MIN = {1'b1, {(SW - 1){1'b0}}};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    logic [DW-1:0]                  s_data    = '0;
    logic                           s_last    = 1'b0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    logic [SLOPE_WIDTH-1:0]         m_data;
    logic [1:0]                     m_user;
    logic                           m_last;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]     cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]      cfg_data  = '0;

    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic rx_hold     = 1'b0;
    logic hold_req    = 1'b0;
    int   cycle_cnt   = 0;
    int   words_sent  = 0;
    int   reg_writes  = 0;
    int   errors;
    int   pending;
    int   results;

    finite_difference_derivative #(
        .SAMPLE_WIDTH(SW)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    fdd_checker #(
        .SAMPLE_WIDTH(SW)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (s_valid),
        .i_s_ready   (s_ready),
        .i_s_data    (s_data[SW-1:0]),
        .i_s_last    (s_last),
        .i_m_valid   (m_valid),
        .i_m_ready   (m_ready),
        .i_m_data    (m_data),
        .i_m_user    (m_user),
        .i_m_last    (m_last),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // long receiver stall so the block backs up into the sample side
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic send_word(input logic [SW-1:0] smp, input logic lst);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= DW'(smp);
        s_last  <= lst;
        @(posedge i_clk);
        while (!s_ready)
            @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_seq(input int len, input int shape);
        logic [SW-1:0] smp;
        logic [SW-1:0] step;
        int            i;
        smp  = SW'($urandom);
        step = SW'($urandom_range(0, 2047)) - SW'(1024);
        for (i = 0; i < len; i++) begin
            case (shape)
                SHAPE_NOISE: smp = SW'($urandom);
                SHAPE_EXTREME: begin
                    case ($urandom_range(0, 3))
                        0:       smp = S_MAX;
                        1:       smp = S_MIN;
                        2:       smp = '0;
                        default: smp = '1;
                    endcase
                end
                SHAPE_RAMP: if (i != 0) smp = smp + step;
                default: smp = SW'($urandom_range(0, 511)) - SW'(256);
            endcase
            send_word(smp, i == len - 1);
        end
    endtask

    // drop valid, wait for every result, then let the pipeline run dry
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        cfg_valid <= 1'b0;
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic configure(input t_mode m, input logic [INV_WIDTH-1:0] inv);
        settle();
        write_reg(CFG_MODE, CFG_DATA_WIDTH'(m));
        write_reg(CFG_INV_STEP, inv);
    endtask

    task automatic configure_random();
        logic [INV_WIDTH-1:0] inv;
        case ($urandom_range(0, 4))
            0:       inv = '0;
            1:       inv = '1;
            2:       inv = INV_STEP_RESET;
            default: inv = INV_WIDTH'($urandom_range(0, 65535));
        endcase
        configure(t_mode'($urandom_range(0, 3)), inv);
    endtask

    initial begin
        int dir_words;
        int phase_end;
        int pick;
        int len;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: forward difference, unit step; a lone sample is too short
        send_word(16'h1234, 1'b1);
        send_word(S_MAX, 1'b0);
        send_word(S_MIN, 1'b0);
        send_word(S_MAX, 1'b0);
        send_word(S_MIN, 1'b1);
        configure(MODE_BWD, '1);
        send_word(S_MIN, 1'b0);
        send_word(S_MAX, 1'b1);
        // five-point needs three samples
        configure(MODE_FIVE, '0);
        send_word(16'd100, 1'b1);
        send_word(16'd100, 1'b0);
        send_word(16'd200, 1'b1);
        configure(MODE_FIVE, INV_STEP_RESET);
        send_word(S_MIN, 1'b0);
        send_word(16'd0, 1'b0);
        send_word(S_MAX, 1'b1);
        // long sequence past the count limit, registers changed part way through
        send_word(S_MAX, 1'b0);
        send_word(S_MIN, 1'b0);
        send_word(16'h0001, 1'b0);
        send_word(16'hfffe, 1'b0);
        send_word(S_MAX, 1'b0);
        configure(MODE_CENTRAL, 16'd1);
        send_word(16'h5555, 1'b0);
        send_word(16'haaaa, 1'b0);
        send_word(S_MIN, 1'b0);
        send_word(S_MAX, 1'b1);
        dir_words = words_sent;

        for (int phase = 0; phase < 3; phase++) begin
            configure_random();
            case (phase)
                0: begin
                    tx_idle_pct  = 27;
                    rx_idle_pct <= 75;
                end
                1: begin
                    tx_idle_pct  = 75;
                    rx_idle_pct <= 27;
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_idle_pct <= 0;
                    hold_req     = 1'b1;
                    send_seq(40, SHAPE_NOISE);
                end
            endcase
            phase_end = dir_words + (phase + 1) * RANDOM_WORDS / 3;
            while (words_sent < phase_end) begin
                if ($urandom_range(0, 3) == 0)
                    configure_random();
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    len = $urandom_range(1, 2);
                else if (pick < 8)
                    len = $urandom_range(3, 10);
                else
                    len = $urandom_range(11, 24);
                send_seq(len, $urandom_range(SHAPE_NOISE, SHAPE_SMALL));
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending != 0)
            $error("%0d expected results never arrived", pending);
        $display("covered %0d sample words and %0d checked results over %0d register writes,",
                 words_sent, results, reg_writes);
        $display("all four difference modes, short sequences and a %0d-cycle output stall",
                 HOLD_CYCLES);
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/fdd_pkg.sv
sv/fdd_front.sv
sv/fdd_scale.sv
sv/fdd_out.sv
sv/finite_difference_derivative.sv
tb/fdd_checker.sv
tb/tb_finite_difference_derivative.sv
